// ----- rtl/core/c2d_pkg.sv -----
// Package: shared types, constants and controller encodings for the conv2d core.
package c2d_pkg;
  localparam int KERNEL_DEF     = 3;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;
  localparam int VALUE_W        = 35;
  localparam int COORD_W        = 6;
  localparam int PIX_W          = 16;
  localparam int SIZE_W         = 7;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic store_pixel;  // write pixel to line store, latch window bounds
    logic load_weight;
    logic start_out;    // set cursor to first output of this pixel
    logic clear_acc;
    logic step_tap;     // accumulate one tap
    logic next_out;     // move cursor to next output
    logic advance;      // step raster counters
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic have_out;     // this pixel causes at least one output
    logic tap_last;     // current tap is the final one of the window
    logic out_last;     // cursor is on the final output of the run
  } stat_t;
endpackage

// ----- rtl/core/c2d_ctrl.sv -----
// Controller: sequences weight loads, pixel stores, window sums and result transfers.
module c2d_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          action,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  c2d_pkg::stat_t stat,
  output c2d_pkg::cmd_t  cmd
);
  import c2d_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (!action) begin
            cmd.load_weight = 1'b1;
          end else begin
            cmd.store_pixel = 1'b1;
            cmd.start_out   = 1'b1;
            cmd.clear_acc   = 1'b1;
            state_next      = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (!stat.have_out) begin
          cmd.advance = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.step_tap = 1'b1;
          if (stat.tap_last) state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (stat.out_last) begin
            cmd.advance = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            cmd.next_out  = 1'b1;
            cmd.clear_acc = 1'b1;
            state_next    = ST_SUM;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  property p_no_in_while_out;
    @(posedge clk) disable iff (rst) out_valid |-> in_stall;
  endproperty
  a_no_in_while_out: assert property (p_no_in_while_out) else $error("input taken during output");

  property p_emit_holds;
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=> out_valid;
  endproperty
  a_emit_holds: assert property (p_emit_holds) else $error("result dropped while stalled");

  property p_sum_then_emit;
    @(posedge clk) disable iff (rst)
      (state == ST_SUM && stat.have_out && stat.tap_last) |=> (state == ST_EMIT);
  endproperty
  a_sum_then_emit: assert property (p_sum_then_emit) else $error("sum not followed by emit");
endmodule

// ----- rtl/core/c2d_datapath.sv -----
// Datapath: weights, line store, raster counters, output cursor and tap accumulator.
module c2d_datapath #(
  parameter int KERNEL     = c2d_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  c2d_pkg::cmd_t                     cmd,
  output c2d_pkg::stat_t                    stat,
  input  logic                              cfg_we,
  input  logic                              cfg_sel,
  input  logic [c2d_pkg::SIZE_W-1:0]        cfg_data,
  output logic [c2d_pkg::SIZE_W-1:0]        width_q,
  output logic [c2d_pkg::SIZE_W-1:0]        height_q,
  input  logic [3:0]                        weight_index,
  input  logic signed [15:0]                weight_value,
  input  logic signed [c2d_pkg::PIX_W-1:0]  pixel,
  output logic signed [c2d_pkg::VALUE_W-1:0] value,
  output logic [c2d_pkg::COORD_W-1:0]       out_x,
  output logic [c2d_pkg::COORD_W-1:0]       out_y,
  output logic                              last_in_run,
  output logic                              end_of_frame
);
  import c2d_pkg::*;

  localparam int TAPS  = KERNEL * KERNEL;
  localparam int TOP   = (KERNEL - 1) / 2;
  localparam int LEAD  = KERNEL - 1 - TOP;
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = (XW > YW ? XW : YW) + 2;   // signed coordinate math
  localparam int KW    = (KERNEL > 1) ? $clog2(KERNEL) : 1;
  localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int XAW   = $clog2(MAX_WIDTH);
  localparam int DEPTH = KERNEL * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // mod KERNEL by reciprocal multiply: q = (x * RM) >> RS is exact for x < 2^CW
  localparam int     RS  = CW + KW;
  localparam longint RM  = ((longint'(1) << RS) + KERNEL - 1) / KERNEL;
  localparam int     RMW = RS + 1;

  function automatic logic [KW-1:0] mod_k(input logic [CW-1:0] x);
    logic [CW+RMW-1:0] q;
    q = ({{RMW{1'b0}}, x} * (CW+RMW)'(RM)) >> RS;
    return KW'(x - CW'(q * (CW+RMW)'(KERNEL)));
  endfunction

  // configured sizes, clamped
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  always_comb begin
    if (width_q == '0) w_eff = XW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(width_q);
    if (height_q == '0) h_eff = YW'(1);
    else if (32'(height_q) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(height_q);
  end

  logic signed [15:0] weights [TAPS];
  logic signed [PIX_W-1:0] lmem [DEPTH];
  logic [XW-1:0] col, ccl;
  logic [YW-1:0] row, rcl;
  logic [KW-1:0] rmod;      // row mod KERNEL, tracked alongside row
  logic [KW-1:0] rmod_c;
  // window of output positions caused by current pixel
  logic [XW-1:0] xlo, xhi, ox;
  logic [YW-1:0] ylo, yhi, oy;
  logic          have;
  logic [KW-1:0] ti, tj;
  logic [TW-1:0] tk;
  logic signed [VALUE_W-1:0] acc;

  always_comb begin
    ccl = (col >= w_eff) ? w_eff - XW'(1) : col;
    rcl = (row >= h_eff) ? h_eff - YW'(1) : row;
    rmod_c = (row >= h_eff) ? mod_k(CW'(h_eff - YW'(1))) : rmod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= SIZE_W'(64);
      height_q <= SIZE_W'(64);
      col <= '0; row <= '0; rmod <= '0;
      for (int i = 0; i < TAPS; i++) weights[i] <= '0;
    end else begin
      if (cmd.load_weight && 32'(weight_index) < TAPS)
        weights[TW'(weight_index)] <= weight_value;
      if (cfg_we) begin
        if (cfg_sel == REG_WIDTH) width_q <= cfg_data;
        else                      height_q <= cfg_data;
        col <= '0; row <= '0; rmod <= '0;
      end else if (cmd.advance) begin
        if (ccl + XW'(1) >= w_eff) begin
          col <= '0;
          if (rcl + YW'(1) >= h_eff) begin
            row <= '0; rmod <= '0;
          end else begin
            row  <= rcl + YW'(1);
            rmod <= (32'(rmod_c) == KERNEL - 1) ? '0 : rmod_c + KW'(1);
          end
        end else begin
          col <= ccl + XW'(1);
          row <= rcl; rmod <= rmod_c;
        end
      end
    end
  end

  // line store write
  always_ff @(posedge clk) begin
    if (cmd.store_pixel)
      lmem[AW'(32'(rmod_c) * MAX_WIDTH + 32'(ccl))] <= pixel;
  end

  // bounds on pixel store
  always_ff @(posedge clk) begin
    if (cmd.store_pixel) begin
      have <= 1'b1;
      if (rcl == h_eff - YW'(1)) begin
        yhi <= h_eff - YW'(1);
        ylo <= (32'(h_eff) - 1 >= LEAD) ? YW'(32'(h_eff) - 1 - LEAD) : '0;
      end else if (32'(rcl) >= LEAD) begin
        ylo <= YW'(32'(rcl) - LEAD); yhi <= YW'(32'(rcl) - LEAD);
      end else have <= 1'b0;
      if (ccl == w_eff - XW'(1)) begin
        xhi <= w_eff - XW'(1);
        xlo <= (32'(w_eff) - 1 >= LEAD) ? XW'(32'(w_eff) - 1 - LEAD) : '0;
      end else if (32'(ccl) >= LEAD) begin
        xlo <= XW'(32'(ccl) - LEAD); xhi <= XW'(32'(ccl) - LEAD);
      end else have <= 1'b0;
    end
  end

  // output cursor: first output set in the cycle after the store (bounds then valid)
  logic first_pend;
  always_ff @(posedge clk) begin
    first_pend <= cmd.start_out;
    if (first_pend) begin ox <= xlo; oy <= ylo; end
    else if (cmd.next_out) begin
      if (ox == xhi) begin ox <= xlo; oy <= oy + YW'(1); end
      else ox <= ox + XW'(1);
    end
  end
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  assign cur_x = first_pend ? xlo : ox;
  assign cur_y = first_pend ? ylo : oy;

  // tap address: one tap per cycle
  logic signed [CW-1:0] py, px;
  logic tap_in;
  logic [KW-1:0] pym;
  always_comb begin
    py = CW'(cur_y) + CW'(ti) - CW'(TOP);
    px = CW'(cur_x) + CW'(tj) - CW'(TOP);
    tap_in = (py >= 0) && (py < CW'(h_eff)) && (px >= 0) && (px < CW'(w_eff));
    pym = mod_k(py[CW-1:0]);
  end

  // registered read and weight, then multiply-accumulate next cycle
  logic signed [PIX_W-1:0] rd_pix;
  logic signed [15:0]      rd_w;
  logic                    rd_ok, rd_v;
  always_ff @(posedge clk) begin
    rd_pix <= lmem[AW'(32'(pym) * MAX_WIDTH + 32'(px[XAW-1:0]))];
    rd_w   <= weights[tk];
    rd_ok  <= tap_in;
  end

  logic signed [31:0] prod;
  assign prod = rd_w * rd_pix;

  // step_tap issues a read; the accumulate lands in the cycle after (in SUM or first EMIT cycle)
  always_ff @(posedge clk) begin
    if (rst) begin
      ti <= '0; tj <= '0; tk <= '0; rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.step_tap;
      if (cmd.clear_acc) begin ti <= '0; tj <= '0; tk <= '0; end
      else if (cmd.step_tap) begin
        tk <= tk + TW'(1);
        if (32'(tj) == KERNEL - 1) begin tj <= '0; ti <= ti + KW'(1); end
        else tj <= tj + KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) acc <= '0;
    else if (rd_v && rd_ok) acc <= acc + VALUE_W'(prod);
  end

  // tap read strobe rd_v registered again: high once its product is in acc
  logic acc_ok;
  always_ff @(posedge clk) begin
    if (rst) acc_ok <= 1'b0;
    else acc_ok <= rd_v;
  end

  assign stat.have_out = have;
  assign stat.tap_last = (32'(tk) == TAPS - 1);
  assign stat.out_last = (cur_x == xhi) && (cur_y == yhi);

  // final product lands on first EMIT edge; show sum including it
  assign value = (rd_v && rd_ok) ? acc + VALUE_W'(prod) : acc;
  assign out_x = COORD_W'(cur_x);
  assign out_y = COORD_W'(cur_y);
  assign last_in_run  = stat.out_last;
  assign end_of_frame = (cur_x == w_eff - XW'(1)) && (cur_y == h_eff - YW'(1));

  property p_acc_ok;
    @(posedge clk) disable iff (rst) cmd.step_tap |-> ##2 acc_ok;
  endproperty
  a_acc_ok: assert property (p_acc_ok) else $error("tap read not tracked");

  property p_cursor_in_box;
    @(posedge clk) disable iff (rst) cmd.next_out |-> (cur_y <= yhi);
  endproperty
  a_cursor_in_box: assert property (p_cursor_in_box) else $error("cursor left window");

  property p_cfg_restart;
    @(posedge clk) disable iff (rst) cfg_we |=> (col == '0 && row == '0);
  endproperty
  a_cfg_restart: assert property (p_cfg_restart) else $error("frame not restarted");
endmodule

// ----- rtl/core/conv2d_same_zero_pad_core.sv -----
// Top level: streaming same-size 2D correlation with zero padding and APB registers.
// Sequence: a pixel that completes no output passes through IDLE and SUM; each output it
// completes is summed in SUM (one tap per cycle through one multiplier), then held in EMIT.
// Items are taken one at a time; a weight load is taken in IDLE, and a pixel at the
// right or bottom edge completes up to (LEAD+1)^2 outputs. Results leave in EMIT only.
// Reset (rst, synchronous): counters to zero, weights to zero, sizes to 64.
// Line store holds no valid bits; entries are read only after they are written.
module conv2d_same_zero_pad_core #(
  parameter int KERNEL     = c2d_pkg::KERNEL_DEF,
  parameter int MAX_WIDTH  = c2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c2d_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              action,
  input  logic [3:0]                        weight_index,
  input  logic signed [15:0]                weight_value,
  input  logic signed [c2d_pkg::PIX_W-1:0]  pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [c2d_pkg::VALUE_W-1:0] value,
  output logic [c2d_pkg::COORD_W-1:0]       out_x,
  output logic [c2d_pkg::COORD_W-1:0]       out_y,
  output logic                              last_in_run,
  output logic                              end_of_frame,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import c2d_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [SIZE_W-1:0] width_q, height_q;
  logic cfg_we;

  // registers at 0 and 4; other addresses take no effect
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'b00) && !paddr[2:2] ? 1'b1 :
                  (psel && penable && pwrite && (paddr == 3'd4));
  assign prdata = (paddr == 3'd4) ? {25'd0, height_q} :
                  (paddr == 3'd0) ? {25'd0, width_q} : 32'd0;

  c2d_ctrl u_ctrl (
    .clk, .rst, .in_valid, .action, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  c2d_datapath #(.KERNEL(KERNEL), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_sel(paddr[2]), .cfg_data(pwdata[SIZE_W-1:0]),
    .width_q, .height_q, .weight_index, .weight_value, .pixel, .value, .out_x, .out_y,
    .last_in_run, .end_of_frame
  );
endmodule

// ----- test/testbench.sv -----
// Testbench for conv2d_same_zero_pad_core: random and directed streams, scoreboard checked.
`timescale 1ns / 100ps

module testbench;
  import c2d_pkg::*;

  localparam int TAPS      = 9;
  localparam int ROW_SPAN  = 64;
  localparam int LIMIT     = 600000;
  localparam int MAX_GAP   = 18;
  localparam int SETTLE    = 60;   // drain margin after the last expected output
  localparam logic ACT_WEIGHT = 1'b0;
  localparam logic ACT_PIXEL  = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    logic               eof;
  } conv_result_t;

  // Scoreboard: holds a shadow copy of the kernel, the line rows and the raster
  // position, and turns every accepted transfer into the outputs it completes.
  class conv_scoreboard;
    logic signed [15:0] weights [TAPS];
    logic signed [15:0] rows [3*ROW_SPAN];
    int unsigned width, height, col, row;
    conv_result_t pending [$];
    int errors, checked;

    function void clear_state();
      foreach (weights[i]) weights[i] = '0;
      foreach (rows[i]) rows[i] = '0;
      col = 0;
      row = 0;
      width = 64;
      height = 64;
    endfunction

    function int unsigned clamp_size(logic [SIZE_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > 64) return 64;
      return 32'(raw);
    endfunction

    function void set_size(logic [0:0] idx, logic [31:0] data);
      if (idx == REG_WIDTH) width = clamp_size(data[SIZE_W-1:0]);
      else height = clamp_size(data[SIZE_W-1:0]);
      col = 0;
      row = 0;
    endfunction

    function logic [VALUE_W-1:0] window_sum(int ox, int oy);
      longint acc;
      int py, px;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        py = oy + i - 1;
        if (py < 0 || py >= int'(height)) continue;
        for (int j = 0; j < 3; j++) begin
          px = ox + j - 1;
          if (px < 0 || px >= int'(width)) continue;
          acc += longint'(weights[i*3+j]) * longint'(rows[(py % 3)*ROW_SPAN + px]);
        end
      end
      return acc[VALUE_W-1:0];
    endfunction

    function void note_item(logic act, logic [3:0] widx, logic [15:0] wval,
                            logic [15:0] pix);
      int unsigned c, r, ylo, yhi, xlo, xhi;
      conv_result_t res;
      bit any;
      if (act == ACT_WEIGHT) begin
        if (widx < TAPS) weights[widx] = wval;
        return;
      end
      c = (col >= width) ? width - 1 : col;
      r = (row >= height) ? height - 1 : row;
      rows[(r % 3)*ROW_SPAN + c] = pix;
      any = 1;
      // bottom row flushes the last two output rows; otherwise lag one row
      if (r == height - 1) begin
        ylo = (height >= 2) ? height - 2 : 0;
        yhi = height - 1;
      end else if (r >= 1) begin
        ylo = r - 1;
        yhi = r - 1;
      end else any = 0;
      if (c == width - 1) begin
        xlo = (width >= 2) ? width - 2 : 0;
        xhi = width - 1;
      end else if (c >= 1) begin
        xlo = c - 1;
        xhi = c - 1;
      end else any = 0;
      if (any) begin
        for (int unsigned oy = ylo; oy <= yhi; oy++) begin
          for (int unsigned ox = xlo; ox <= xhi; ox++) begin
            res.value = window_sum(ox, oy);
            res.x = ox[COORD_W-1:0];
            res.y = oy[COORD_W-1:0];
            res.last = (oy == yhi && ox == xhi);
            res.eof = (ox == width - 1 && oy == height - 1);
            pending.push_back(res);
          end
        end
      end
      c++;
      if (c >= width) begin
        c = 0;
        r++;
        if (r >= height) r = 0;
      end
      col = c;
      row = r;
    endfunction

    function void report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endfunction

    function void check_result(conv_result_t got);
      conv_result_t want;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected output at (%0d,%0d)", got.x, got.y));
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value)
        report($sformatf("value at (%0d,%0d): got %h want %h",
                         want.x, want.y, got.value, want.value));
      if (got.x !== want.x || got.y !== want.y)
        report($sformatf("position: got (%0d,%0d) want (%0d,%0d)",
                         got.x, got.y, want.x, want.y));
      if (got.last !== want.last)
        report($sformatf("last_in_run at (%0d,%0d): got %b", want.x, want.y, got.last));
      if (got.eof !== want.eof)
        report($sformatf("end_of_frame at (%0d,%0d): got %b", want.x, want.y, got.eof));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_WEIGHT;
  logic [3:0] weight_index = '0;
  logic signed [15:0] weight_value = '0;
  logic signed [PIX_W-1:0] pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VALUE_W-1:0] value;
  logic [COORD_W-1:0] out_x, out_y;
  logic last_in_run, end_of_frame;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  conv_scoreboard sb = new();
  int cycles = 0;
  int pixels_sent = 0, weights_sent = 0, size_writes = 0;
  int stall_left = 0;
  bit in_burst = 0, out_burst = 0;

  conv2d_same_zero_pad_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall before each result; burst mode stalls never.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result('{value, out_x, out_y, last_in_run, end_of_frame});
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      stall_left = out_burst ? 0 : $urandom_range(0, MAX_GAP);
    end
  end

  // One input transfer. Valid stays high between back-to-back transfers.
  task automatic send_item(logic act, logic [3:0] widx, logic [15:0] wval,
                           logic [15:0] pix);
    int gap;
    if ($urandom_range(0, 24) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    weight_index = widx;
    weight_value = wval;
    pixel = pix;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, widx, wval, pix);
    if (act == ACT_PIXEL) pixels_sent++;
    else weights_sent++;
  endtask

  task automatic send_pixel(logic [15:0] pix);
    send_item(ACT_PIXEL, 4'($urandom_range(0, 15)), 16'($urandom), pix);
  endtask

  task automatic send_weight(logic [3:0] widx, logic [15:0] wval);
    send_item(ACT_WEIGHT, widx, wval, 16'($urandom));
  endtask

  // Drain: nothing pending, then let any output-free pixel finish.
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // APB write: setup then access; pready is tied high in the core.
  task automatic write_size(logic [0:0] idx, logic [SIZE_W-1:0] raw);
    logic [31:0] data;
    data = {$urandom} & ~32'h7F | 32'(raw);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_size(idx, data);
    size_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int w_raw, h_raw, n, rand_items;
    sb.clear_state();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: extreme weights, ignored weight indexes, pixels at reset size
    for (int k = 0; k < TAPS; k++) send_weight(4'(k), (k % 2) ? 16'h7FFF : 16'h8000);
    send_weight(4'd9, 16'h1234);
    send_weight(4'd15, 16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    wait_idle();
    // Zero size acts as a 1x1 frame: every pixel is a whole frame
    write_size(REG_WIDTH, 7'd0);
    write_size(REG_HEIGHT, 7'd0);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    wait_idle();
    // 3x3 frame of full-scale pixels, with a weight change mid-frame
    write_size(REG_WIDTH, 7'd3);
    write_size(REG_HEIGHT, 7'd3);
    for (int p = 0; p < 9; p++) begin
      if (p == 5) send_weight(4'd4, 16'h4000);
      send_pixel(p[0] ? 16'h7FFF : 16'h8000);
    end
    wait_idle();

    // Random phases: mostly small frames, occasionally the clamped maximum
    rand_items = 0;
    while (rand_items < 300) begin
      case ($urandom_range(0, 9))
        0: begin w_raw = $urandom_range(65, 127); h_raw = $urandom_range(0, 2); end
        1: begin w_raw = $urandom_range(0, 3); h_raw = $urandom_range(64, 127); end
        2: begin w_raw = 64; h_raw = 1; end
        default: begin w_raw = $urandom_range(1, 8); h_raw = $urandom_range(1, 6); end
      endcase
      write_size(REG_WIDTH, SIZE_W'(w_raw));
      write_size(REG_HEIGHT, SIZE_W'(h_raw));
      n = sb.width * sb.height * $urandom_range(1, 2) + $urandom_range(0, 5);
      if (n > 90) n = 90;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_weight(4'($urandom_range(0, 15)), 16'($urandom));
        else send_pixel(rand_pixel());
        rand_items++;
      end
      wait_idle();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected outputs never arrived", sb.pending.size()));
    $display("Sent %0d pixels and %0d weight loads over %0d size writes;",
             pixels_sent, weights_sent, size_writes);
    $display("checked %0d outputs, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
